>>> rtl/imm_pkg.sv
package imm_pkg;

    // Character and pattern geometry
    localparam int CHAR_W            = 8;
    localparam int PAT_CHARS         = 16;
    localparam int PAT_WORD_CHARS    = 8;
    localparam int PAT_WORD_W        = 64;
    localparam int LEN_W             = 5;
    localparam int MODE_W            = 2;
    localparam int START_W           = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_W      = 2;

    typedef logic [CHAR_W-1:0] t_char;

    // Search modes; the unused code behaves as exact match
    localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IUPAC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIMER = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd3;

    // Reset value of the pattern length register
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    // Character codes
    localparam t_char CH_A  = 8'h41;
    localparam t_char CH_B  = 8'h42;
    localparam t_char CH_C  = 8'h43;
    localparam t_char CH_D  = 8'h44;
    localparam t_char CH_G  = 8'h47;
    localparam t_char CH_H  = 8'h48;
    localparam t_char CH_K  = 8'h4B;
    localparam t_char CH_M  = 8'h4D;
    localparam t_char CH_N  = 8'h4E;
    localparam t_char CH_R  = 8'h52;
    localparam t_char CH_S  = 8'h53;
    localparam t_char CH_T  = 8'h54;
    localparam t_char CH_V  = 8'h56;
    localparam t_char CH_W  = 8'h57;
    localparam t_char CH_Y  = 8'h59;
    localparam t_char CH_LA = 8'h61;
    localparam t_char CH_LZ = 8'h7A;
    localparam t_char CASE_OFFSET = 8'h20;

    // Configuration as seen by the cells
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [MODE_W-1:0] mode;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [START_W-1:0] start_position;
        logic               forward_match;
        logic               reverse_match;
    } t_result;

    // Upper-case a..z only
    function automatic t_char to_upper(input t_char c);
        t_char r;
        r = c;
        if (c >= CH_LA && c <= CH_LZ) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // Base complement; anything that is not A, C, G or T becomes N
    function automatic t_char complement(input t_char c);
        t_char r;
        case (c)
            CH_A:    r = CH_T;
            CH_T:    r = CH_A;
            CH_C:    r = CH_G;
            CH_G:    r = CH_C;
            default: r = CH_N;
        endcase
        return r;
    endfunction

    // IUPAC degenerate base test of a sequence char against a pattern char
    function automatic logic iupac_ok(input t_char p, input t_char s);
        logic ok;
        case (p)
            CH_R:    ok = s inside {CH_A, CH_G};
            CH_Y:    ok = s inside {CH_C, CH_T};
            CH_K:    ok = s inside {CH_G, CH_T};
            CH_M:    ok = s inside {CH_A, CH_C};
            CH_S:    ok = s inside {CH_C, CH_G};
            CH_W:    ok = s inside {CH_A, CH_T};
            CH_B:    ok = s inside {CH_C, CH_G, CH_T};
            CH_D:    ok = s inside {CH_A, CH_G, CH_T};
            CH_H:    ok = s inside {CH_A, CH_C, CH_T};
            CH_V:    ok = s inside {CH_A, CH_C, CH_G};
            default: ok = 1'b0;
        endcase
        return ok || (p == CH_N) || (p == s);
    endfunction

endpackage

>>> rtl/iupac_dna_motif_matcher_core.sv
// IUPAC DNA motif matcher.
// Input channel: one sequence byte per item (i_symbol), with i_new_sequence
// clearing the window fill and the position before the byte is taken. An item
// is accepted when i_in_valid is high and o_in_stall is low.
// Output channel: one result item per input item, in order: the start position
// of the window ending at that byte and the forward and reverse match flags.
// A result is taken when o_out_valid is high and i_out_stall is low.
// Throughput is one item per cycle while o_in_stall is low. An accepted byte's
// match bits are registered in the window cells, combined into a result item and
// written into the output queue, whose head drives the output. The queue holds
// three results; o_in_stall rises when the queue plus the item in flight reach
// that depth, so a stalled receiver holds the input back after at most three
// more items, and no result is lost. Configuration goes in through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must do so only while the block is idle,
// as the block does not enforce it. Reset empties the pipeline and queue, clears
// fill and position, and sets pattern chars to zero, length to one, exact mode.
module iupac_dna_motif_matcher_core #(
    parameter int PATTERN_MAX   = imm_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = imm_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [imm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [imm_pkg::CHAR_W-1:0]          i_symbol,
    input  logic                                i_new_sequence,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [imm_pkg::START_W-1:0]         o_start_position,
    output logic                                o_forward_match,
    output logic                                o_reverse_match
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int LW     = imm_pkg::LEN_W;
    localparam int QW     = imm_pkg::QCNT_W;

    // Configuration registers
    logic [imm_pkg::PAT_WORD_W-1:0] r_pat_lo;
    logic [imm_pkg::PAT_WORD_W-1:0] r_pat_hi;
    logic [LW-1:0]                  r_len;
    logic [imm_pkg::MODE_W-1:0]     r_mode;

    imm_pkg::t_char [imm_pkg::PAT_CHARS-1:0] pattern;
    imm_pkg::t_cfg                           cfg;
    logic [LW-1:0]                           len_eff;

    // Sequence state and the stage after the cells
    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        n_fill;
    logic [POSITION_BITS-1:0] r_idx;
    logic [POSITION_BITS-1:0] n_idx;
    logic [POSITION_BITS-1:0] cur_idx;
    logic                     r_s1_valid;
    logic [POSITION_BITS-1:0] r_s1_pos;
    logic [FILL_W-1:0]        r_s1_fill;

    logic                          accept;
    imm_pkg::t_char                sym_up;
    imm_pkg::t_char [PATTERN_MAX-1:0] cell_char;
    logic [PATTERN_MAX-1:0]        cell_fwd;
    logic [PATTERN_MAX-1:0]        cell_rev;

    imm_pkg::t_result              result;
    logic [POSITION_BITS-1:0]      start_full;
    logic [POSITION_BITS-1:0]      len_m1;
    logic                          q_valid;
    imm_pkg::t_result              q_head;
    logic [QW-1:0]                 q_count;
    logic [QW:0]                   in_flight;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= imm_pkg::LEN_RESET;
            r_mode   <= imm_pkg::MODE_EXACT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                imm_pkg::CFG_PAT_LO: r_pat_lo <= i_cfg_data;
                imm_pkg::CFG_PAT_HI: r_pat_hi <= i_cfg_data;
                imm_pkg::CFG_LEN:    r_len    <= i_cfg_data[LW-1:0];
                imm_pkg::CFG_MODE:   r_mode   <= i_cfg_data[imm_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Upper-cased pattern chars and the length clamped to the window size.
    always_comb begin
        for (int i = 0; i < imm_pkg::PAT_WORD_CHARS; i++) begin
            pattern[i] = imm_pkg::to_upper(r_pat_lo[i*imm_pkg::CHAR_W +: imm_pkg::CHAR_W]);
            pattern[i + imm_pkg::PAT_WORD_CHARS] =
                imm_pkg::to_upper(r_pat_hi[i*imm_pkg::CHAR_W +: imm_pkg::CHAR_W]);
        end
    end

    assign len_eff  = (r_len > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : r_len;
    assign cfg.len  = len_eff;
    assign cfg.mode = r_mode;

    // Input handshake: hold back once the queue and the item in flight fill it.
    assign in_flight  = (QW + 1)'(q_count) + (QW + 1)'(r_s1_valid);
    assign o_in_stall = (in_flight >= (QW + 1)'(imm_pkg::QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign sym_up     = imm_pkg::to_upper(i_symbol);

    // Fill count and position, both cleared ahead of a new sequence.
    always_comb begin
        cur_idx = i_new_sequence ? '0 : r_idx;
        n_idx   = (&cur_idx) ? cur_idx : cur_idx + POSITION_BITS'(1);
        if (i_new_sequence) begin
            n_fill = FILL_W'(1);
        end else if (r_fill == FILL_W'(PATTERN_MAX)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_fill  <= '0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_fill    <= n_fill;
                r_idx     <= n_idx;
                r_s1_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= cur_idx;
        end
    end

    // Chain of window cells; the newest char enters at the top cell.
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        imm_pkg::t_char cell_in;
        if (j == PATTERN_MAX - 1) begin : g_top
            assign cell_in = sym_up;
        end else begin : g_mid
            assign cell_in = cell_char[j + 1];
        end
        imm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .CELL_IDX    (j)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (accept),
            .i_char    (cell_in),
            .i_pattern (pattern),
            .i_cfg     (cfg),
            .o_char    (cell_char[j]),
            .o_fwd_ok  (cell_fwd[j]),
            .o_rev_ok  (cell_rev[j])
        );
    end

    // Combine the cell match bits into one result item.
    assign len_m1 = POSITION_BITS'(len_eff) - POSITION_BITS'(1);

    always_comb begin
        start_full            = '0;
        result.forward_match  = 1'b0;
        result.reverse_match  = 1'b0;
        if (len_eff == '0) begin
            start_full = r_s1_pos;
        end else if (LW'(r_s1_fill) >= len_eff) begin
            start_full            = (r_s1_pos >= len_m1) ? r_s1_pos - len_m1 : '0;
            result.forward_match  = &cell_fwd;
            result.reverse_match  = (r_mode == imm_pkg::MODE_PRIMER) && (&cell_rev);
        end
        result.start_position = imm_pkg::START_W'(start_full);
    end

    // Output queue
    imm_result_q u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (result),
        .i_pop   (!i_out_stall),
        .o_valid (q_valid),
        .o_data  (q_head),
        .o_count (q_count)
    );

    assign o_out_valid      = q_valid;
    assign o_start_position = q_head.start_position;
    assign o_forward_match  = q_head.forward_match;
    assign o_reverse_match  = q_head.reverse_match;

endmodule

>>> rtl/imm_cell.sv
module imm_cell #(
    parameter int PATTERN_MAX = imm_pkg::PATTERN_MAX_DEF,
    parameter int CELL_IDX    = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_shift,
    input  imm_pkg::t_char                            i_char,
    input  imm_pkg::t_char [imm_pkg::PAT_CHARS-1:0]   i_pattern,
    input  imm_pkg::t_cfg                             i_cfg,
    output imm_pkg::t_char                            o_char,
    output logic                                      o_fwd_ok,
    output logic                                      o_rev_ok
);

    localparam int SUM_W   = imm_pkg::LEN_W + 1;
    localparam int PIDX_W  = $clog2(imm_pkg::PAT_CHARS);
    localparam int REV_IDX = PATTERN_MAX - 1 - CELL_IDX;

    logic [SUM_W-1:0]  sum;
    logic              in_range;
    logic [PIDX_W-1:0] fwd_idx;
    imm_pkg::t_char    fwd_pat;
    logic              fwd_hit;
    logic              rev_hit;
    imm_pkg::t_char    r_char;
    logic              r_fwd_ok;
    logic              r_rev_ok;

    // This cell lies inside the window when its place plus the length reaches the top.
    assign sum      = SUM_W'(CELL_IDX) + SUM_W'(i_cfg.len);
    assign in_range = (sum >= SUM_W'(PATTERN_MAX));
    assign fwd_idx  = PIDX_W'(sum - SUM_W'(PATTERN_MAX));
    assign fwd_pat  = i_pattern[fwd_idx];

    // Compare the incoming char against its forward and reverse pattern chars.
    always_comb begin
        if (i_cfg.mode == imm_pkg::MODE_IUPAC) begin
            fwd_hit = imm_pkg::iupac_ok(fwd_pat, i_char);
        end else begin
            fwd_hit = (fwd_pat == i_char);
        end
        rev_hit = (imm_pkg::complement(i_pattern[REV_IDX]) == i_char);
    end

    // The char and its match bits move on together with every accepted item.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_char   <= i_char;
            r_fwd_ok <= fwd_hit || !in_range;
            r_rev_ok <= rev_hit || !in_range;
        end
    end

    assign o_char   = r_char;
    assign o_fwd_ok = r_fwd_ok;
    assign o_rev_ok = r_rev_ok;

endmodule

>>> rtl/imm_result_q.sv
module imm_result_q (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  imm_pkg::t_result               i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output imm_pkg::t_result               o_data,
    output logic [imm_pkg::QCNT_W-1:0]     o_count
);

    localparam int DEPTH = imm_pkg::QUEUE_DEPTH;
    localparam int CW    = imm_pkg::QCNT_W;

    imm_pkg::t_result [DEPTH-1:0] r_q;
    imm_pkg::t_result [DEPTH-1:0] n_q;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                n_cnt;
    logic                         pop;
    logic [CW-1:0]                wr_slot;

    assign pop     = i_pop && (r_cnt != '0);
    assign wr_slot = r_cnt - CW'(pop);

    // Shift towards the head on a pop, then place a new item behind the last one.
    always_comb begin
        for (int s = 0; s < DEPTH; s++) begin
            if (pop && (s < DEPTH - 1)) begin
                n_q[s] = r_q[s + 1];
            end else begin
                n_q[s] = r_q[s];
            end
            if (i_push && (CW'(s) == wr_slot)) begin
                n_q[s] = i_data;
            end
        end
        n_cnt = r_cnt + CW'(i_push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[0];
    assign o_count = r_cnt;

endmodule
